>>> src/cfds_pkg.sv
// Package for the camera follow core: shared types, constants and the datapath opcodes.
// No dependencies.
`default_nettype none
package cfds_pkg;
  typedef enum logic [3:0] {
    OP_IDLE, OP_START, OP_EDIT, OP_PSY, OP_GOALY, OP_SMX, OP_SMY, OP_CLAMP,
    OP_SHK1, OP_SHK2, OP_SHK3, OP_SHK4, OP_OUT
  } cfds_op_e;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} cfds_state_e;

  typedef struct packed {
    cfds_op_e op;
    logic     load;
    logic     out_load;
  } cfds_cmd_t;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_MIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_AMP   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FREQ  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LEN   = 3'd7;

  localparam logic signed [47:0] S24Max = 48'sd8388607;
  localparam logic signed [47:0] S24Min = -48'sd8388608;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > S24Max) return 24'sh7FFFFF;
    if (v < S24Min) return 24'sh800000;
    return v[23:0];
  endfunction
endpackage
`default_nettype wire

>>> src/cfds_ctrl.sv
// Controller for the camera follow core: sequences the datapath steps of one word.
// Depends on cfds_pkg.
`default_nettype none
module cfds_ctrl
  import cfds_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_fire_i,
  input  wire logic      editor_i,
  input  wire logic      out_busy_i,
  output logic           in_ready_o,
  output cfds_cmd_t      cmd_o
);
  cfds_state_e state_q, state_d;
  cfds_op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_IDLE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: op_q, load: 1'b0, out_load: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = OP_START;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          op_d       = editor_i ? OP_EDIT : OP_PSY;
        end
      end
      ST_RUN: begin
        case (op_q)
          OP_EDIT:  op_d = OP_OUT;
          OP_PSY:   op_d = OP_GOALY;
          OP_GOALY: op_d = OP_SMX;
          OP_SMX:   op_d = OP_SMY;
          OP_SMY:   op_d = OP_CLAMP;
          OP_CLAMP: op_d = OP_SHK1;
          OP_SHK1:  op_d = OP_SHK2;
          OP_SHK2:  op_d = OP_SHK3;
          OP_SHK3:  op_d = OP_SHK4;
          OP_SHK4:  op_d = OP_OUT;
          OP_OUT:   state_d = ST_HOLD;
          default:  op_d = OP_OUT;
        endcase
      end
      ST_HOLD: begin
        if (!out_busy_i) begin
          cmd_o.op       = OP_OUT;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
          op_d           = OP_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> src/cfds_dp.sv
// Datapath for the camera follow core: state, config registers, one shared multiplier.
// Depends on cfds_pkg.
`default_nettype none
module cfds_dp
  import cfds_pkg::*;
#(
  parameter int ScreenWidth  = 1600,
  parameter int ScreenHeight = 900
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cfds_cmd_t               cmd_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic [69:0]        in_data_i,
  output logic [96:0]             res_o
);
  localparam logic signed [47:0] HalfW = 48'(ScreenWidth * 128);
  localparam logic signed [47:0] HalfH = 48'(ScreenHeight * 128);
  localparam logic signed [47:0] H5    = 48'(ScreenHeight * 256 * 5);
  localparam logic signed [47:0] H7    = 48'(ScreenHeight * 256 * 7);
  // ceil(2^30 / 5): exact floor division by 5 below 2^30
  localparam logic [27:0]        RecipFive = 28'd214748365;

  logic signed [23:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic [22:0] speed_q, amp_q;
  logic [15:0] freq_q;
  logic [23:0] len_q;

  logic signed [23:0] cam_x_q, cam_y_q, off_q;
  logic               down_q, on_q;
  logic [23:0]        el_q;

  logic               ed_q, up_q, dn_q, lf_q, rt_q;
  logic signed [23:0] tx_q, ty_q;
  logic [15:0]        ft_q;

  logic signed [47:0] a_q, b_q, nx_q, ny_q;
  logic signed [59:0] prod_q;
  logic               hi_q;
  logic [96:0]        res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0; min_y_q <= '0; max_x_q <= '0; max_y_q <= '0;
      speed_q <= 23'd512000; amp_q <= '0; freq_q <= '0; len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_X: min_x_q <= cfg_data_i;
        REG_MIN_Y: min_y_q <= cfg_data_i;
        REG_MAX_X: max_x_q <= cfg_data_i;
        REG_MAX_Y: max_y_q <= cfg_data_i;
        REG_SPEED: speed_q <= cfg_data_i[22:0];
        REG_AMP:   amp_q   <= cfg_data_i[22:0];
        REG_FREQ:  freq_q  <= cfg_data_i[15:0];
        REG_LEN:   len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier: at most 40x20 bits per cycle, registered.
  logic signed [39:0] m_a;
  logic signed [19:0] m_b;
  always_comb begin
    m_a = '0;
    m_b = '0;
    case (cmd_i.op)
      OP_EDIT:  begin m_a = 40'(speed_q); m_b = 20'(ft_q); end
      OP_SMX:   begin m_a = 40'(tx_q) - 40'(cam_x_q); m_b = 20'(ft_q) * 20'sd5; end
      OP_SMY:   begin m_a = 40'(a_q - 48'(cam_y_q)); m_b = 20'(ft_q) * 20'sd2; end
      OP_CLAMP: begin m_a = 40'(amp_q); m_b = 20'(freq_q); end
      OP_SHK1:  begin m_a = 40'(prod_q); m_b = 20'(ft_q); end
      default: ;
    endcase
  end

  function automatic logic signed [47:0] fshr16(input logic signed [59:0] v);
    return 48'(v >>> 16);
  endfunction

  function automatic logic signed [47:0] clampv(input logic signed [47:0] v,
                                                input logic signed [47:0] lo,
                                                input logic signed [47:0] hi);
    logic signed [47:0] r;
    r = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  logic signed [47:0] psy10, off_n, mag, over, el_n, hi_n, ed_step;
  logic [53:0]        q_m;
  logic signed [23:0] vy;
  always_comb begin
    psy10   = a_q * 48'sd10;
    hi_n    = (psy10 - H7) >>> 2;
    q_m     = 54'(a_q[25:0]) * 54'(RecipFive);
    ed_step = fshr16(prod_q);
    off_n   = 48'(off_q) + (down_q ? b_q : -b_q);
    mag     = off_n < 0 ? -off_n : off_n;
    over    = mag - 48'(amp_q);
    el_n    = 48'(el_q) + 48'(ft_q);
    vy      = sat24(48'(cam_y_q) + 48'(off_q) - HalfH);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= m_a * m_b;
    if (cmd_i.out_load)
      res_q <= {on_q, vy, sat24(48'(cam_x_q) - HalfW), cam_y_q, cam_x_q};
    if (cmd_i.load) begin
      ed_q <= in_data_i[0]; up_q <= in_data_i[1]; dn_q <= in_data_i[2];
      lf_q <= in_data_i[3]; rt_q <= in_data_i[4];
      tx_q <= in_data_i[28:5]; ty_q <= in_data_i[52:29]; ft_q <= in_data_i[68:53];
    end
    case (cmd_i.op)
      OP_PSY:   a_q <= 48'(ty_q) - (48'(cam_y_q) - HalfH);
      OP_GOALY: begin
        if (psy10 < H5) begin
          a_q  <= -((HalfH - a_q) >>> 1);
          hi_q <= 1'b0;
        end else if (psy10 > H7) begin
          a_q  <= hi_n;
          hi_q <= 1'b1;
        end else begin
          a_q  <= '0;
          hi_q <= 1'b0;
        end
      end
      OP_SMX:   a_q  <= 48'(cam_y_q) + (hi_q ? 48'(q_m[53:30]) : a_q);
      OP_SMY:   nx_q <= 48'(cam_x_q) + fshr16(prod_q);
      OP_CLAMP: ny_q <= 48'(cam_y_q) + fshr16(prod_q);
      OP_SHK2:  b_q  <= 48'(prod_q >>> 22);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= 24'(ScreenWidth * 128);
      cam_y_q <= 24'(ScreenHeight * 128);
      off_q <= '0; down_q <= 1'b1; el_q <= '0; on_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_START: if (cmd_i.load && in_data_i[69]) begin
          on_q <= 1'b1; off_q <= '0; down_q <= 1'b1; el_q <= '0;
        end
        OP_OUT: if (ed_q && !cmd_i.out_load) begin
          cam_y_q <= sat24(48'(cam_y_q) - (up_q ? ed_step : 48'sd0)
                           + (dn_q ? ed_step : 48'sd0));
          cam_x_q <= sat24(48'(cam_x_q) - (lf_q ? ed_step : 48'sd0)
                           + (rt_q ? ed_step : 48'sd0));
        end
        OP_SHK1: begin
          cam_x_q <= sat24(clampv(nx_q, 48'(min_x_q) + HalfW, 48'(max_x_q) - HalfW));
          cam_y_q <= sat24(clampv(ny_q, 48'(min_y_q) + HalfH, 48'(max_y_q) - HalfH));
        end
        OP_SHK3: if (on_q) begin
          if (mag > 48'(amp_q)) begin
            off_q  <= sat24(off_n + (down_q ? -over : over));
            down_q <= !down_q;
          end else begin
            off_q <= sat24(off_n);
          end
          el_q <= (el_n > 48'hFFFFFF) ? 24'hFFFFFF : el_n[23:0];
        end
        OP_SHK4: if (on_q && el_q > len_q) begin
          el_q <= '0; on_q <= 1'b0; off_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

>>> src/camera_follow_deadzone_shake_core.sv
// Top level of the camera follow core with deadzone and shake.
// Depends on cfds_pkg, cfds_ctrl, cfds_dp.
// One word per frame; each accepted word runs through the controller's step sequence
// around one shared multiplier (a shorter one in editor mode), and no new word is taken
// until that word's result has been loaded into the output register. A result waits in its
// register; the next word may be taken meanwhile, and its result holds until the
// prior one has been taken. No clearing pass after reset.
`default_nettype none
module camera_follow_deadzone_shake_core
  import cfds_pkg::*;
#(
  parameter int ScreenWidth  = 1600,
  parameter int ScreenHeight = 900
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // editor_mode, key_up, key_down, key_left, key_right, target_x, target_y,
  // frame_time, start_shake, zero fill
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // center_x, center_y, view_offset_x, view_offset_y, shaking, zero fill
  output logic [103:0]     m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  cfds_cmd_t   cmd;
  logic        in_ready, vld_q;
  logic [96:0] res;

  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;

  cfds_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (s_axis_tvalid && in_ready),
    .editor_i   (s_axis_tdata[0]),
    .out_busy_i (vld_q && !m_axis_tready),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  cfds_dp #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i,
    .in_data_i  (s_axis_tdata[69:0]),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (cmd.out_load) vld_q <= 1'b1;
    else if (m_axis_tready) vld_q <= 1'b0;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {7'd0, res};
endmodule
`default_nettype wire

>>> src/cfds_checker.sv
// Port checker for the camera follow core, bound to the top level.
// Depends on camera_follow_deadzone_shake_core.
`default_nettype none
module cfds_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second word taken");
  a_noout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
    |=> !m_axis_tvalid) else $error("result too early");
endmodule

bind camera_follow_deadzone_shake_core cfds_checker u_chk (.*);
`default_nettype wire

>>> dv/camera_follow_deadzone_shake_core_tb.sv
// Testbench for camera_follow_deadzone_shake_core: directed frames, then random frames
// over several register settings, checked against an in-bench camera and shake predictor.
// Depends on cfds_pkg and the RTL of the core.
`timescale 1ns / 100ps
module camera_follow_deadzone_shake_core_tb;
  import cfds_pkg::*;

  localparam int ScreenW = 1600;
  localparam int ScreenH = 900;
  localparam longint HalfW = ScreenW * 128;
  localparam longint HalfH = ScreenH * 128;
  localparam longint HeightQ8 = ScreenH * 256;
  localparam longint CycleLimit = 600000;
  localparam int NumRand = 320;

  typedef struct {
    bit               editor, up, down, left, right, start;
    logic signed [23:0] tx, ty;
    logic [15:0]      ft;
  } frame_t;

  typedef struct {
    logic signed [23:0] cx, cy, vx, vy;
    logic             shaking;
  } view_t;

  typedef struct {
    frame_t f;
    bit     typed;
    view_t  v;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_valid_i = 0;
  logic [71:0] s_axis_tdata = '0;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready_o;
  logic [103:0] m_axis_tdata;

  camera_follow_deadzone_shake_core dut (.*);

  // register copies and camera state
  longint min_x, min_y, max_x, max_y, speed, amp, freq, len;
  longint cam_x, cam_y, shk_off, shk_el;
  bit shk_down, shk_on;

  view_t view_q[$];
  int errors = 0, n_frames = 0, n_views = 0;
  int rx_mode = 0, tx_mode = 0;
  longint cycles = 0;

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint clip24(input longint v);
    return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
  endfunction

  task automatic cam_predict(input frame_t f, output view_t v);
    longint ft, d, nx, ny, goal, psy, step, mag, over, tx, ty;
    ft = longint'(f.ft);
    tx = longint'(f.tx);
    ty = longint'(f.ty);
    if (f.start) begin
      shk_on = 1; shk_off = 0; shk_down = 1; shk_el = 0;
    end
    if (f.editor) begin
      d = (speed * ft) >> 16;
      if (f.up) cam_y -= d;
      if (f.down) cam_y += d;
      if (f.left) cam_x -= d;
      if (f.right) cam_x += d;
      cam_x = clip24(cam_x);
      cam_y = clip24(cam_y);
    end else begin
      goal = cam_y;
      psy = ty - (cam_y - HalfH);
      nx = cam_x + (((tx - cam_x) * (5 * ft)) >>> 16);
      if (psy * 10 < 5 * HeightQ8) goal = cam_y - (5 * HeightQ8 - psy * 10) / 20;
      else if (psy * 10 > 7 * HeightQ8) goal = cam_y + (psy * 10 - 7 * HeightQ8) / 20;
      ny = cam_y + (((goal - cam_y) * (2 * ft)) >>> 16);
      if (nx > max_x - HalfW) nx = max_x - HalfW;
      if (nx < min_x + HalfW) nx = min_x + HalfW;
      if (ny > max_y - HalfH) ny = max_y - HalfH;
      if (ny < min_y + HalfH) ny = min_y + HalfH;
      cam_x = clip24(nx);
      cam_y = clip24(ny);
      if (shk_on) begin
        step = (amp * freq * ft) >> 22;
        shk_off += shk_down ? step : -step;
        mag = shk_off < 0 ? -shk_off : shk_off;
        if (mag > amp) begin
          over = mag - amp;
          shk_off += shk_down ? -over : over;
          shk_down = !shk_down;
        end
        shk_off = clip24(shk_off);
        shk_el += ft;
        if (shk_el > 24'hFFFFFF) shk_el = 24'hFFFFFF;
        if (shk_el > len) begin
          shk_el = 0; shk_on = 0; shk_off = 0;
        end
      end
    end
    v.cx = cam_x[23:0];
    v.cy = cam_y[23:0];
    v.vx = 24'(clip24(cam_x - HalfW));
    v.vy = 24'(clip24(cam_y + shk_off - HalfH));
    v.shaking = shk_on;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_MIN_X: min_x = longint'($signed(val));
      REG_MIN_Y: min_y = longint'($signed(val));
      REG_MAX_X: max_x = longint'($signed(val));
      REG_MAX_Y: max_y = longint'($signed(val));
      REG_SPEED: speed = val[22:0];
      REG_AMP:   amp = val[22:0];
      REG_FREQ:  freq = val[15:0];
      default:   len = val;
    endcase
  endtask

  task automatic write_all(input logic [23:0] r[8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), r[i]);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // hand one frame to the core, then maybe open a gap
  int burst_left = 0;
  task automatic send_frame(input frame_t f, input bit typed, input view_t tv);
    view_t pv;
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, f.start, f.ft, f.ty, f.tx, f.right, f.left, f.down, f.up,
                     f.editor};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cam_predict(f, pv);
    view_q.push_back(typed ? tv : pv);
    n_frames++;
    if (tx_mode != 0) begin
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 6);
        gap = $urandom_range(1, 5);
        @(negedge clk_i);
        s_axis_tvalid <= 0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (view_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] near(input longint c);
    longint r;
    r = longint'($urandom_range(0, (1 << $urandom_range(4, 20)) - 1));
    if ($urandom_range(0, 1)) r = -r;
    return 24'(clip24(c + r));
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int k;
    k = $urandom_range(0, 99);
    {f.up, f.down, f.left, f.right} = 4'($urandom);
    f.editor = k < 12;
    f.start = $urandom_range(0, 19) == 0;
    f.ft = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(200, 3000));
    if (k >= 90) begin
      f.tx = 24'($urandom);
      f.ty = 24'($urandom);
    end else begin
      f.tx = near(cam_x);
      f.ty = near(cam_y + HalfH / 5);
    end
    return f;
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 0;
    else case (rx_mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= $urandom_range(0, 3) != 0;
      default: m_axis_tready <= (cycles % 23) < 14;
    endcase
  end

  always @(posedge clk_i) begin
    view_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_views++;
      if (view_q.size() == 0) begin
        $error("result with no expectation: %h", m_axis_tdata);
        errors++;
      end else begin
        e = view_q.pop_front();
        if (m_axis_tdata[23:0] !== e.cx) begin
          $error("center_x exp %0d got %0d", e.cx, $signed(m_axis_tdata[23:0])); errors++;
        end
        if (m_axis_tdata[47:24] !== e.cy) begin
          $error("center_y exp %0d got %0d", e.cy, $signed(m_axis_tdata[47:24])); errors++;
        end
        if (m_axis_tdata[71:48] !== e.vx) begin
          $error("view_offset_x exp %0d got %0d", e.vx, $signed(m_axis_tdata[71:48]));
          errors++;
        end
        if (m_axis_tdata[95:72] !== e.vy) begin
          $error("view_offset_y exp %0d got %0d", e.vy, $signed(m_axis_tdata[95:72]));
          errors++;
        end
        if (m_axis_tdata[96] !== e.shaking) begin
          $error("shaking exp %0d got %0d", e.shaking, m_axis_tdata[96]); errors++;
        end
      end
    end
  end

  row_t rows[$];
  logic [23:0] cfg_set[5][8];

  function automatic row_t mk(input bit ed, input logic [3:0] keys, input int tx, input int ty,
                              input int ft, input bit st);
    row_t r;
    r.f.editor = ed;
    {r.f.up, r.f.down, r.f.left, r.f.right} = keys;
    r.f.tx = 24'(tx); r.f.ty = 24'(ty); r.f.ft = 16'(ft); r.f.start = st;
    r.typed = 0;
    return r;
  endfunction

  initial begin
    row_t r;
    frame_t f;
    view_t none;
    min_x = 0; min_y = 0; max_x = 0; max_y = 0; speed = 512000;
    amp = 0; freq = 0; len = 0;
    cam_x = HalfW; cam_y = HalfH; shk_off = 0; shk_el = 0; shk_down = 1; shk_on = 0;

    // after reset, zero frame time: centre stays at half screen
    r = mk(1, 4'b0000, 0, 0, 0, 0);
    r.typed = 1;
    r.v.cx = 24'(HalfW); r.v.cy = 24'(HalfH); r.v.vx = 0; r.v.vy = 0; r.v.shaking = 0;
    rows.push_back(r);
    rows.push_back(mk(1, 4'b1000, 0, 0, 65535, 0));
    rows.push_back(mk(1, 4'b0100, 0, 0, 65535, 0));
    rows.push_back(mk(1, 4'b0010, 0, 0, 1092, 1));
    rows.push_back(mk(1, 4'b0001, 0, 0, 1092, 0));
    rows.push_back(mk(1, 4'b1100, 0, 0, 40000, 0));
    rows.push_back(mk(1, 4'b1111, 0, 0, 40000, 0));
    rows.push_back(mk(1, 4'b1010, 0, 0, 65535, 0));
    rows.push_back(mk(1, 4'b0101, 0, 0, 65535, 0));
    rows.push_back(mk(0, 4'b1111, 8388607, 8388607, 65535, 0));
    rows.push_back(mk(0, 4'b0000, -8388608, -8388608, 65535, 1));
    rows.push_back(mk(0, 4'b0000, 0, 0, 0, 0));
    rows.push_back(mk(0, 4'b0000, 300000, 100000, 1092, 1));
    rows.push_back(mk(0, 4'b0000, -300000, 150000, 30000, 0));

    cfg_set[0] = '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'd512000, 24'd2560,
                   24'd1280, 24'd65536};
    cfg_set[1] = '{24'd0, 24'd0, 24'd409600, 24'd230400, 24'h7FFFFF, 24'h7FFFFF,
                   24'hFFFF, 24'hFFFFFF};
    cfg_set[2] = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
    cfg_set[3] = '{24'd300000, 24'd200000, 24'd100000, 24'd50000, 24'd90000, 24'd100000,
                   24'd4000, 24'd200000};
    for (int i = 0; i < 8; i++) cfg_set[4][i] = 24'($urandom);
    cfg_set[4][0] = 24'hFC0000; cfg_set[4][1] = 24'hFC0000;
    cfg_set[4][2] = 24'h040000; cfg_set[4][3] = 24'h040000;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    foreach (rows[i]) send_frame(rows[i].f, rows[i].typed, rows[i].v);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_all(cfg_set[p]);
      rx_mode = p % 3;
      tx_mode = (p + 1) % 3;
      for (int n = 0; n < NumRand; n++) begin
        f = rand_frame();
        send_frame(f, 0, none);
      end
      drain();
    end

    $display("Sent %0d frames over six register settings; %0d results checked.",
             n_frames, n_views);
    if (errors == 0 && view_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

>>> files.f
src/cfds_pkg.sv
src/cfds_ctrl.sv
src/cfds_dp.sv
src/camera_follow_deadzone_shake_core.sv
src/cfds_checker.sv
dv/camera_follow_deadzone_shake_core_tb.sv
